// ----- src/affine_matrix_inverse_assert.svh -----
// Assertion macros used by the checker file of the affine matrix inverse.
// No dependencies; each macro expands to one concurrent assertion.
`ifndef AFFINE_MATRIX_INVERSE_ASSERT_SVH
`define AFFINE_MATRIX_INVERSE_ASSERT_SVH
// same-cycle implication
`define AMI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define AMI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/aminv_pkg.sv -----
// Shared constants and types of the affine matrix inverse.
// No dependencies.
`timescale 1ns / 1ps
package aminv_pkg;
   localparam int NUM_LIN    = 9;
   localparam int NUM_AXES   = 3;
   localparam int NUM_GROUPS = 4;
   localparam logic [1:0] GROUP_LAST = 2'd3;

   typedef struct packed {
      logic en;
      logic neg;
   } aminv_lane_ctl_type;
endpackage

// ----- src/aminv_div.sv -----
// Pipelined restoring divider lane: rounded, saturated cofactor / determinant.
// Depends on aminv_pkg. One quotient bit per stage, WORD_BITS + 2 stages.
`timescale 1ns / 1ps
module aminv_div #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  aminv_pkg::aminv_lane_ctl_type    ctl,
   input  logic [2*WORD_BITS-1:0]           num_mag,
   input  logic [3*WORD_BITS-1:0]           den,
   output logic signed [WORD_BITS-1:0]      quo
);
   localparam int W  = WORD_BITS;
   localparam int NW = 2 * W;
   localparam int DW = 3 * W;
   localparam int AW = NW + 2 * FRAC_BITS;
   localparam int HW = AW - W;
   localparam int CW = (HW > DW) ? HW : DW;
   localparam int RW = DW + 1;
   localparam logic [W:0] LimNeg = (W + 1)'(1) << (W - 1);
   localparam logic [W:0] LimPos = LimNeg - (W + 1)'(1);

   logic [AW-1:0] dividend;
   logic [CW-1:0] top_c;
   logic [CW-1:0] den_c;
   logic [DW-1:0] rem_ff [W+1];
   logic [DW-1:0] den_ff [W+1];
   logic [W-1:0]  low_ff [W+1];
   logic [W-1:0]  q_ff   [W+1];
   logic          ovf_ff [W+1];
   logic          neg_ff [W+1];
   logic          rnd;
   logic [W:0]    q_rnd;
   logic [W:0]    lim;
   logic [W:0]    mag;
   logic [W:0]    sgn;
   logic signed [W-1:0] quo_ff;

   assign dividend = AW'(num_mag) << (2 * FRAC_BITS);
   assign top_c    = CW'(dividend[AW-1:W]);
   assign den_c    = CW'(den);

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         rem_ff[0] <= top_c[DW-1:0];
         den_ff[0] <= den;
         low_ff[0] <= dividend[W-1:0];
         q_ff[0]   <= '0;
         ovf_ff[0] <= top_c >= den_c;
         neg_ff[0] <= ctl.neg;
      end
   end

   for (genvar i = 0; i < W; i++) begin : g_step
      logic [RW-1:0] sh;
      logic          ge;
      assign sh = {rem_ff[i], low_ff[i][W-1]};
      assign ge = sh >= {1'b0, den_ff[i]};
      always_ff @(posedge clock) begin
         if (ctl.en) begin
            rem_ff[i+1] <= ge ? DW'(sh - {1'b0, den_ff[i]}) : sh[DW-1:0];
            den_ff[i+1] <= den_ff[i];
            low_ff[i+1] <= low_ff[i] << 1;
            q_ff[i+1]   <= {q_ff[i][W-2:0], ge};
            ovf_ff[i+1] <= ovf_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   // round half up on the remainder, then clamp
   always_comb begin
      rnd   = {rem_ff[W], 1'b0} >= {1'b0, den_ff[W]};
      q_rnd = {1'b0, q_ff[W]} + (W + 1)'(rnd);
      lim   = neg_ff[W] ? LimNeg : LimPos;
      mag   = (ovf_ff[W] || (q_rnd > lim)) ? lim : q_rnd;
      sgn   = neg_ff[W] ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         quo_ff <= sgn[W-1:0];
      end
   end

   assign quo = quo_ff;
endmodule

// ----- src/affine_matrix_inverse.sv -----
// Affine 4x4 matrix inverse in signed fixed point, top level.
// Depends on aminv_pkg and aminv_div.
//
// Usage: one request beat carries the 3x3 linear block and the translation of
// an affine matrix, each element signed with FRAC_BITS fraction bits. The
// block returns the inverse as four response beats, groups 0 to 3 in order,
// last_of_run marking group 3. A zero determinant gives all-zero elements
// with singular_flag set on all four beats.
// The first response beat follows the request beat through the pipeline and the
// response buffer; the other three follow back to back unless the receiver stalls.
// Throughput: the datapath takes a new matrix every cycle while req_stall is low;
// the response port sets the sustained rate, as each matrix takes four beats.
// The divider lanes are the deep part: one quotient bit per stage.
// Reset clears all valid bits and the response buffer; no beat is in flight.
// When the receiver stalls, the response beat holds and, once the buffer and
// the last pipeline stage are both full, the whole pipeline freezes and
// req_stall rises; nothing is dropped or repeated.
`timescale 1ns / 1ps
module affine_matrix_inverse #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_in_0,
   input  logic signed [WORD_BITS-1:0] req_in_1,
   input  logic signed [WORD_BITS-1:0] req_in_2,
   input  logic signed [WORD_BITS-1:0] req_in_4,
   input  logic signed [WORD_BITS-1:0] req_in_5,
   input  logic signed [WORD_BITS-1:0] req_in_6,
   input  logic signed [WORD_BITS-1:0] req_in_8,
   input  logic signed [WORD_BITS-1:0] req_in_9,
   input  logic signed [WORD_BITS-1:0] req_in_10,
   input  logic signed [WORD_BITS-1:0] req_in_12,
   input  logic signed [WORD_BITS-1:0] req_in_13,
   input  logic signed [WORD_BITS-1:0] req_in_14,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_group,
   output logic signed [WORD_BITS-1:0] rsp_elem_a,
   output logic signed [WORD_BITS-1:0] rsp_elem_b,
   output logic signed [WORD_BITS-1:0] rsp_elem_c,
   output logic signed [WORD_BITS-1:0] rsp_elem_d,
   output logic                        rsp_singular_flag,
   output logic                        rsp_last_of_run
);
   import aminv_pkg::*;

   localparam int W    = WORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2 * W;
   localparam int NW   = 2 * W + 1;
   localparam int DTW  = 3 * W + 2;
   localparam int DETW = 3 * W + 3;
   localparam int DW   = 3 * W;
   localparam int SW   = 2 * W + 2;
   localparam int NST  = W + 10;
   localparam int TDEP = W + 8;
   localparam int SDEP = W + 5;
   localparam logic [SW:0] Half   = (SW + 1)'(1) << (F - 1);
   localparam logic [SW:0] LimNeg = (SW + 1)'(1) << (W - 1);
   localparam logic [SW:0] LimPos = LimNeg - (SW + 1)'(1);
   localparam logic [W-1:0] UnitVal =
      (F < W - 1) ? (W'(1) << F) : {1'b0, {(W - 1){1'b1}}};
   // cofactor k = lin[a] * lin[b] - lin[c] * lin[d], lin in row-major order
   localparam int CofOp [NUM_LIN][4] = '{
      '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
      '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}};

   logic signed [W-1:0]  lin [NUM_LIN];
   logic signed [W-1:0]  trans [NUM_AXES];

   logic [NST-1:0]       v_ff;
   logic signed [PW-1:0] pa_ff [NUM_LIN];
   logic signed [PW-1:0] pb_ff [NUM_LIN];
   logic signed [W-1:0]  c0_ff [2][NUM_AXES];
   logic signed [NW-1:0] npipe_ff [4][NUM_LIN];
   logic signed [2*W:0]  pl_ff [NUM_AXES];
   logic signed [2*W:0]  ph_ff [NUM_AXES];
   logic signed [DTW-1:0] dt_ff [NUM_AXES];
   logic signed [DETW-1:0] det_ff;
   logic [DW-1:0]        dmag_ff;
   logic [PW-1:0]        nmag_ff [NUM_LIN];
   logic                 neg6_ff [NUM_LIN];
   logic                 sing_ff [SDEP];
   logic signed [W-1:0]  tpipe_ff [TDEP][NUM_AXES];
   logic signed [W-1:0]  quo [NUM_LIN];
   logic signed [PW-1:0] tp_ff [NUM_AXES][NUM_AXES];
   logic signed [W-1:0]  rq_ff [NUM_LIN];
   logic signed [W-1:0]  rq2_ff [NUM_LIN];
   logic signed [SW-1:0] sum_ff [NUM_AXES];

   logic                 tneg [NUM_AXES];
   logic [SW-1:0]        tmag [NUM_AXES];
   logic [SW:0]          trnd [NUM_AXES];
   logic [SW:0]          tlim [NUM_AXES];
   logic [SW:0]          tsat [NUM_AXES];
   logic signed [W-1:0]  tres [NUM_AXES];

   logic signed [W-1:0]  hold_ff [NUM_GROUPS][NUM_AXES];
   logic                 hsing_ff;
   logic                 full_ff;
   logic                 full_in;
   logic [1:0]           grp_ff;
   logic [1:0]           grp_in;
   logic                 beat;
   logic                 last_beat;
   logic                 hold_free;
   logic                 adv;
   logic                 load;

   assign lin[0] = req_in_0;
   assign lin[1] = req_in_1;
   assign lin[2] = req_in_2;
   assign lin[3] = req_in_4;
   assign lin[4] = req_in_5;
   assign lin[5] = req_in_6;
   assign lin[6] = req_in_8;
   assign lin[7] = req_in_9;
   assign lin[8] = req_in_10;
   assign trans[0] = req_in_12;
   assign trans[1] = req_in_13;
   assign trans[2] = req_in_14;

   assign beat      = full_ff && !rsp_stall;
   assign last_beat = beat && (grp_ff == GROUP_LAST);
   assign hold_free = !full_ff || last_beat;
   assign adv       = !v_ff[NST-1] || hold_free;
   assign load      = v_ff[NST-1] && hold_free;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], req_valid};
      end
   end

   // front end: cofactors, determinant, magnitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NUM_LIN; j++) begin
            pa_ff[j] <= lin[CofOp[j][0]] * lin[CofOp[j][1]];
            pb_ff[j] <= lin[CofOp[j][2]] * lin[CofOp[j][3]];
            npipe_ff[0][j] <= NW'(pa_ff[j]) - NW'(pb_ff[j]);
            for (int s = 1; s < 4; s++) begin
               npipe_ff[s][j] <= npipe_ff[s-1][j];
            end
         end
         for (int k = 0; k < NUM_AXES; k++) begin
            c0_ff[0][k] <= lin[3 * k];
            c0_ff[1][k] <= c0_ff[0][k];
            pl_ff[k] <= c0_ff[1][k] * $signed({1'b0, npipe_ff[0][k][W-1:0]});
            ph_ff[k] <= c0_ff[1][k] * $signed(npipe_ff[0][k][NW-1:W]);
            dt_ff[k] <= (DTW'(ph_ff[k]) <<< W) + DTW'(pl_ff[k]);
         end
         det_ff  <= DETW'(dt_ff[0]) + DETW'(dt_ff[1]) + DETW'(dt_ff[2]);
         dmag_ff <= DW'(det_ff[DETW-1] ? -det_ff : det_ff);
         for (int j = 0; j < NUM_LIN; j++) begin
            nmag_ff[j] <= PW'(npipe_ff[3][j][NW-1] ? -npipe_ff[3][j] : npipe_ff[3][j]);
            neg6_ff[j] <= npipe_ff[3][j][NW-1] ^ det_ff[DETW-1];
         end
         sing_ff[0] <= det_ff == '0;
         for (int s = 1; s < SDEP; s++) begin
            sing_ff[s] <= sing_ff[s-1];
         end
         for (int r = 0; r < NUM_AXES; r++) begin
            tpipe_ff[0][r] <= trans[r];
            for (int s = 1; s < TDEP; s++) begin
               tpipe_ff[s][r] <= tpipe_ff[s-1][r];
            end
         end
      end
   end

   for (genvar j = 0; j < NUM_LIN; j++) begin : g_lane
      aminv_lane_ctl_type ctl;
      assign ctl.en  = adv;
      assign ctl.neg = neg6_ff[j];
      aminv_div #(
         .WORD_BITS(WORD_BITS),
         .FRAC_BITS(FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .ctl     (ctl),
         .num_mag (nmag_ff[j]),
         .den     (dmag_ff),
         .quo     (quo[j])
      );
   end

   // back end: new translation = -(t * inverse block)
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            for (int r = 0; r < NUM_AXES; r++) begin
               tp_ff[i][r] <= tpipe_ff[TDEP-1][r] * quo[3 * r + i];
            end
            sum_ff[i] <= SW'(tp_ff[i][0]) + SW'(tp_ff[i][1]) + SW'(tp_ff[i][2]);
         end
         for (int j = 0; j < NUM_LIN; j++) begin
            rq_ff[j]  <= quo[j];
            rq2_ff[j] <= rq_ff[j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         tneg[i] = !sum_ff[i][SW-1] && (sum_ff[i] != '0);
         tmag[i] = sum_ff[i][SW-1] ? SW'(-sum_ff[i]) : SW'(sum_ff[i]);
         trnd[i] = ((SW + 1)'(tmag[i]) + Half) >> F;
         tlim[i] = tneg[i] ? LimNeg : LimPos;
         tsat[i] = (trnd[i] > tlim[i]) ? tlim[i] : trnd[i];
         tres[i] = tneg[i] ? W'(-tsat[i]) : W'(tsat[i]);
      end
   end

   // response buffer, drained one group per beat
   always_comb begin
      full_in = full_ff;
      grp_in  = grp_ff;
      if (load) begin
         full_in = 1'b1;
         grp_in  = '0;
      end else if (last_beat) begin
         full_in = 1'b0;
      end else if (beat) begin
         grp_in = grp_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         grp_ff  <= '0;
      end else begin
         full_ff <= full_in;
         grp_ff  <= grp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hsing_ff <= sing_ff[SDEP-1];
         for (int e = 0; e < NUM_AXES; e++) begin
            for (int g = 0; g < NUM_AXES; g++) begin
               hold_ff[g][e] <= sing_ff[SDEP-1] ? '0 : rq2_ff[3 * g + e];
            end
            hold_ff[NUM_GROUPS-1][e] <= sing_ff[SDEP-1] ? '0 : tres[e];
         end
      end
   end

   assign rsp_valid         = full_ff;
   assign rsp_group         = grp_ff;
   assign rsp_elem_a        = hold_ff[grp_ff][0];
   assign rsp_elem_b        = hold_ff[grp_ff][1];
   assign rsp_elem_c        = hold_ff[grp_ff][2];
   assign rsp_elem_d        = ((grp_ff == GROUP_LAST) && !hsing_ff) ? UnitVal : '0;
   assign rsp_singular_flag = hsing_ff;
   assign rsp_last_of_run   = grp_ff == GROUP_LAST;
endmodule

// ----- src/aminv_check.sv -----
// Port-level checker of the affine matrix inverse, bound to the top level.
// Depends on aminv_pkg and affine_matrix_inverse_assert.svh.
`timescale 1ns / 1ps
`include "affine_matrix_inverse_assert.svh"
module aminv_check #(
   parameter int WORD_BITS = 32
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [1:0]                  rsp_group,
   input logic signed [WORD_BITS-1:0] rsp_elem_a,
   input logic signed [WORD_BITS-1:0] rsp_elem_b,
   input logic signed [WORD_BITS-1:0] rsp_elem_c,
   input logic signed [WORD_BITS-1:0] rsp_elem_d,
   input logic                        rsp_singular_flag,
   input logic                        rsp_last_of_run
);
   import aminv_pkg::*;

   `AMI_ASSERT_NEXT(a_group_step, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last_of_run,
      rsp_valid && (rsp_group == $past(rsp_group) + 2'd1),
      "group sequence broken inside a run")
   `AMI_ASSERT_NOW(a_last_group, clock, reset, rsp_valid,
      rsp_last_of_run == (rsp_group == GROUP_LAST), "last_of_run off group 3")
   `AMI_ASSERT_NOW(a_singular_zero, clock, reset, rsp_valid && rsp_singular_flag,
      rsp_elem_a == '0 && rsp_elem_b == '0 && rsp_elem_c == '0 && rsp_elem_d == '0,
      "singular beat with nonzero element")
   `AMI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_group) && $stable(rsp_elem_a),
      "stalled response beat changed")
endmodule

bind affine_matrix_inverse aminv_check #(.WORD_BITS(WORD_BITS)) u_check (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for affine_matrix_inverse: drives matrices, predicts
// the four inverse beats of each one and compares them. Depends on aminv_pkg and affine_matrix_inverse.
`timescale 1ns / 1ps
module testbench;
   import aminv_pkg::*;

   localparam int WB = 32;
   localparam int FB = 16;
   localparam int WATCH_LIMIT = 4000;

   typedef struct {
      logic [WB-1:0] e[12];
      bit            drain;
   } matrix_type;

   typedef struct {
      logic [1:0]    group;
      logic [WB-1:0] el[4];
      logic          sing;
      logic          last;
   } inv_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [WB-1:0] req_in[12] = '{default: '0};
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_group;
   logic signed [WB-1:0] rsp_elem_a, rsp_elem_b, rsp_elem_c, rsp_elem_d;
   logic rsp_singular_flag, rsp_last_of_run;

   matrix_type   pending[$];
   inv_beat_type inv_beats[$];
   int        mismatches = 0;
   int        gap_left = 0;
   int        stall_left = 0;
   int        idle_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   affine_matrix_inverse #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_in_0(req_in[0]), .req_in_1(req_in[1]), .req_in_2(req_in[2]),
      .req_in_4(req_in[3]), .req_in_5(req_in[4]), .req_in_6(req_in[5]),
      .req_in_8(req_in[6]), .req_in_9(req_in[7]), .req_in_10(req_in[8]),
      .req_in_12(req_in[9]), .req_in_13(req_in[10]), .req_in_14(req_in[11]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_group(rsp_group),
      .rsp_elem_a(rsp_elem_a), .rsp_elem_b(rsp_elem_b), .rsp_elem_c(rsp_elem_c),
      .rsp_elem_d(rsp_elem_d), .rsp_singular_flag(rsp_singular_flag),
      .rsp_last_of_run(rsp_last_of_run)
   );

   function automatic logic [WB-1:0] clamp_word(logic signed [255:0] mag, bit neg);
      logic signed [255:0] lim;
      logic signed [255:0] v;
      lim = neg ? (256'sd1 <<< (WB-1)) : ((256'sd1 <<< (WB-1)) - 1);
      v = (mag > lim) ? lim : mag;
      if (neg) v = -v;
      return v[WB-1:0];
   endfunction

   function automatic logic signed [255:0] wide(logic [WB-1:0] x);
      return 256'($signed(x));
   endfunction

   task automatic predict_inverse(input matrix_type m);
      logic signed [255:0] f[16];
      logic signed [255:0] n[16];
      logic signed [255:0] det, dmag, num, s;
      logic [WB-1:0] r[16];
      int pos[12];
      int lin[9];
      bit sing;
      inv_beat_type b;
      pos = '{0, 1, 2, 4, 5, 6, 8, 9, 10, 12, 13, 14};
      lin = '{0, 1, 2, 4, 5, 6, 8, 9, 10};
      for (int i = 0; i < 16; i++) begin
         f[i] = '0;
         n[i] = '0;
         r[i] = '0;
      end
      for (int i = 0; i < 12; i++) f[pos[i]] = wide(m.e[i]);
      n[0]  = f[5] * f[10] - f[9] * f[6];
      n[1]  = f[9] * f[2]  - f[1] * f[10];
      n[2]  = f[1] * f[6]  - f[5] * f[2];
      n[4]  = f[8] * f[6]  - f[4] * f[10];
      n[5]  = f[0] * f[10] - f[8] * f[2];
      n[6]  = f[4] * f[2]  - f[0] * f[6];
      n[8]  = f[4] * f[9]  - f[8] * f[5];
      n[9]  = f[8] * f[1]  - f[0] * f[9];
      n[10] = f[0] * f[5]  - f[4] * f[1];
      det = f[0] * n[0] + f[4] * n[1] + f[8] * n[2];
      sing = (det == 0);
      if (!sing) begin
         dmag = (det < 0) ? -det : det;
         for (int i = 0; i < 9; i++) begin
            num = n[lin[i]] <<< (2 * FB);
            if (num < 0) num = -num;
            num = (2 * num + dmag) / (2 * dmag);
            r[lin[i]] = clamp_word(num, (n[lin[i]] < 0) != (det < 0));
         end
         for (int i = 0; i < 3; i++) begin
            s = -(f[12] * wide(r[i]) + f[13] * wide(r[4+i]) + f[14] * wide(r[8+i]));
            num = (s < 0) ? -s : s;
            num = (num + (256'sd1 <<< (FB-1))) >>> FB;
            r[12+i] = clamp_word(num, s < 0);
         end
         r[15] = WB'(1) << FB;
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
         b.group = 2'(g);
         for (int j = 0; j < 4; j++) b.el[j] = r[4*g+j];
         b.sing = sing;
         b.last = (2'(g) == GROUP_LAST);
         inv_beats.push_back(b);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 20);
   endfunction

   // driver
   always @(posedge clock) begin
      automatic bit fire = req_valid && !req_stall;
      automatic matrix_type m;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            m.drain = 0;
            for (int i = 0; i < 12; i++) m.e[i] = req_in[i];
            predict_inverse(m);
         end
         if (!req_valid || fire) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending.size() > 0 &&
                         !(pending[0].drain && inv_beats.size() > 0)) begin
               m = pending.pop_front();
               for (int i = 0; i < 12; i++) req_in[i] <= m.e[i];
               req_valid <= 1'b1;
               gap_left <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      automatic inv_beat_type x;
      automatic logic [WB-1:0] got[4];
      automatic bit bad;
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_left <= pick_gap();
            rsp_stall <= 1'b0;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_elem_a, rsp_elem_b, rsp_elem_c, rsp_elem_d};
            if (inv_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: group %0d a %h", rsp_group, rsp_elem_a);
            end else begin
               x = inv_beats.pop_front();
               bad = (x.group !== rsp_group) || (x.sing !== rsp_singular_flag) ||
                     (x.last !== rsp_last_of_run);
               for (int j = 0; j < 4; j++) if (x.el[j] !== got[j]) bad = 1;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp g%0d %h %h %h %h s%0d l%0d",
                              x.group, x.el[0], x.el[1], x.el[2], x.el[3], x.sing, x.last);
                     $display("          got g%0d %h %h %h %h s%0d l%0d",
                              rsp_group, got[0], got[1], got[2], got[3],
                              rsp_singular_flag, rsp_last_of_run);
                  end
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic matrix_type diag_matrix(logic [WB-1:0] a, logic [WB-1:0] b,
                                              logic [WB-1:0] c);
      matrix_type m;
      foreach (m.e[i]) m.e[i] = '0;
      m.e[0] = a;
      m.e[4] = b;
      m.e[8] = c;
      m.drain = 0;
      return m;
   endfunction

   function automatic logic [WB-1:0] near_fix(int span);
      return WB'($signed($urandom_range(2 * span)) - span);
   endfunction

   initial begin
      matrix_type m;
      int kind;
      // directed
      pending.push_back(diag_matrix(32'h10000, 32'h10000, 32'h10000));
      m = diag_matrix(32'h20000, 32'hFFFF0000, 32'h8000);
      m.e[9] = 32'h7FFFFFFF; m.e[10] = 32'h80000000; m.e[11] = 32'h12345;
      pending.push_back(m);
      pending.push_back(diag_matrix('0, '0, '0));
      m = diag_matrix(32'h10000, 32'h10000, 32'h10000);
      m.e[1] = 32'h10000; m.e[3] = 32'h10000; m.e[4] = 32'h10000;
      pending.push_back(m);
      pending.push_back(diag_matrix(32'h1, 32'h1, 32'h1));
      pending.push_back(diag_matrix(32'hFFFFFFFF, 32'h1, 32'h1));
      m = diag_matrix(32'h1, 32'h1, 32'h1);
      m.e[9] = 32'h7FFFFFFF; m.e[10] = 32'h80000000; m.e[11] = 32'h7FFFFFFF;
      pending.push_back(m);
      pending.push_back(diag_matrix(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      pending.push_back(diag_matrix(32'h80000000, 32'h80000000, 32'h80000000));
      foreach (m.e[i]) m.e[i] = 32'h7FFFFFFF;
      pending.push_back(m);
      foreach (m.e[i]) m.e[i] = 32'h80000000;
      pending.push_back(m);
      m = diag_matrix(32'h18000, 32'h8000, 32'h30000);
      m.e[9] = 32'h8000; m.e[10] = 32'hFFFF8000; m.e[11] = 32'h18000;
      pending.push_back(m);
      m = diag_matrix(32'h10000, 32'h10000, 32'h10000);
      m.e[9] = 32'h30000;
      m.drain = 1;
      pending.push_back(m);
      // random
      for (int n = 0; n < 200; n++) begin
         kind = $urandom_range(9);
         for (int i = 0; i < 12; i++)
            m.e[i] = (kind < 6) ? near_fix(kind < 3 ? 32'h30000 : 32'h800) : $urandom;
         if (kind < 6) begin
            m.e[0] = m.e[0] + 32'h40000;
            m.e[4] = m.e[4] + 32'h40000;
            m.e[8] = m.e[8] + 32'h40000;
         end
         if (kind == 9)
            for (int i = 0; i < 3; i++) m.e[3+i] = m.e[i];
         m.drain = ($urandom_range(49) == 0);
         pending.push_back(m);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && !req_valid && inv_beats.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && inv_beats.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

// ----- affine_matrix_inverse.f -----
+incdir+src
src/aminv_pkg.sv
src/aminv_div.sv
src/affine_matrix_inverse.sv
src/aminv_check.sv
verif/testbench.sv
